// ===== src/dplt_pkg.sv =====
// Shared constants, result codes and controller states of the paging translator.
`timescale 1ns / 1ps
package dplt_pkg;

	localparam int DefPageBytes = 64;
	localparam int DefVirtPages = 64;
	localparam int DefFrames    = 16;
	localparam int DefSwapSlots = 64;
	localparam int DefStampBits = 32;

	localparam logic [2:0] STS_HIT   = 3'd0;
	localparam logic [2:0] STS_FAULT = 3'd1;
	localparam logic [2:0] STS_RANGE = 3'd2;
	localparam logic [2:0] STS_RO    = 3'd3;
	localparam logic [2:0] STS_FULL  = 3'd4;

	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_EXE  = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;
	localparam logic [1:0] SRC_SWAP = 2'd3;

	localparam logic [2:0] REG_TEXT   = 3'd0;
	localparam logic [2:0] REG_DATA   = 3'd1;
	localparam logic [2:0] REG_PAGES  = 3'd2;
	localparam logic [2:0] REG_FRAMES = 3'd3;
	localparam logic [2:0] REG_SLOTS  = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PT,
		S_SCAN,
		S_VPT,
		S_SWAP,
		S_FILL
	} state_t;

endpackage

// ===== src/dplt_ram.sv =====
// Single-port-write, registered-read memory whose unwritten entries read as zero.
`timescale 1ns / 1ps
module dplt_ram #(
	parameter int W  = 8,
	parameter int D  = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];
	logic [D-1:0] seen_q;
	logic [W-1:0] rd_q;
	logic         seen_q1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// An entry never written since reset reads as zero. A read in the
	// same cycle as a write to that entry returns the old contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			seen_q1 <= 1'b0;
		end else begin
			if (we) begin
				seen_q[waddr] <= 1'b1;
			end
			if (re) begin
				seen_q1 <= seen_q[raddr];
			end
		end
	end

	assign rdata = seen_q1 ? rd_q : '0;

endmodule

// ===== src/demand_paging_lru_translator_unit.sv =====
// Top level of the demand-paging address translator with LRU frame replacement.
`timescale 1ns / 1ps
// A beat is accepted when start is high and busy is low; the result appears with
// done high for exactly one cycle and cannot be held off. Range and read-only
// rejects are answered straight from idle, and hits after the page table read. A
// fault then reads the frame table one entry a cycle, stopping at the first free
// frame or scanning all nf active frames when none is free; it next reads the page
// entry of the victim frame's owner if it has one, and a dirty victim then searches
// the swap slot table in order for a free slot. PAGE_BYTES must be a power of two.
module demand_paging_lru_translator_unit #(
	parameter int PAGE_BYTES = dplt_pkg::DefPageBytes,
	parameter int VIRT_PAGES = dplt_pkg::DefVirtPages,
	parameter int FRAMES     = dplt_pkg::DefFrames,
	parameter int SWAP_SLOTS = dplt_pkg::DefSwapSlots,
	parameter int STAMP_BITS = dplt_pkg::DefStampBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [11:0] vaddr,
	output logic        done,
	output logic [2:0]  status,
	output logic [9:0]  paddr,
	output logic [1:0]  fill_source,
	output logic [5:0]  fill_index,
	output logic        evict_valid,
	output logic [5:0]  evict_page,
	output logic        writeback_valid,
	output logic [5:0]  writeback_slot,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [6:0]  wr_data
);

	localparam int OW  = $clog2(PAGE_BYTES);
	localparam int VW  = 12 - OW;
	localparam int PW  = (VIRT_PAGES > 1) ? $clog2(VIRT_PAGES) : 1;
	localparam int FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int SW  = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
	localparam int IW  = (FW > SW) ? FW : SW;
	localparam int PEW = IW + 3;
	localparam int FRW = 1 + PW + STAMP_BITS;
	localparam logic [STAMP_BITS-1:0] StampMax = {STAMP_BITS{1'b1}};

	function automatic logic [9:0] phys_of(input logic [FW-1:0] f, input logic [OW-1:0] o);
		phys_of = 10'((32'(f) << OW) | 32'(o));
	endfunction

	dplt_pkg::state_t state_q, state_d;

	logic [6:0] text_q, data_q, pages_q, slots_q;
	logic [4:0] frames_q;

	logic                  req_q;
	logic [PW-1:0]         page_q;
	logic [OW-1:0]         off_q;
	logic [PEW-1:0]        e_q;
	logic [FW-1:0]         frame_q, scan_q, best_q;
	logic [STAMP_BITS-1:0] min_q, stamp_q;
	logic [PW:0]           bown_q;
	logic [PW-1:0]         vp_q;
	logic [SW-1:0]         sw_q, wbs_q;
	logic                  ev_q, wb_q;

	logic                  done_q, ev_o_q, wb_o_q;
	logic [2:0]            status_q;
	logic [9:0]            phys_q;
	logic [1:0]            src_q;
	logic [5:0]            fidx_q, evp_o_q, wbs_o_q;

	logic                  pt_re, pt_we, fm_re, fm_we, sm_re, sm_we, sm_wdata;
	logic [PW-1:0]         pt_raddr, pt_waddr;
	logic [PEW-1:0]        pt_wdata, pt_rdata;
	logic [FW-1:0]         fm_raddr, fm_waddr;
	logic [FRW-1:0]        fm_wdata, fm_rdata;
	logic [SW-1:0]         sm_raddr, sm_waddr;
	logic                  sm_rdata;

	logic                  res_ld, r_ev, r_wb, stamp_take;
	logic [2:0]            r_status;
	logic [9:0]            r_phys;
	logic [1:0]            r_src;
	logic [5:0]            r_fidx, r_evp, r_wbs;

	logic [VW-1:0]         page_in;
	logic                  in_range, ro_hit;
	logic [8:0]            nf;
	logic [10:0]           ns;

	logic [STAMP_BITS-1:0] cur_stamp;
	logic [PW:0]           cur_own;
	logic                  sc_free, sc_last, sc_better;
	logic [FW-1:0]         sc_best;
	logic [PW:0]           sc_own;
	logic                  v_match, v_needwb, s_free, s_last;

	logic                  pv, pd, ps;
	logic [IW-1:0]         pidx;
	logic                  e_swapped;
	logic [IW-1:0]         e_idx;

	assign page_in  = vaddr[11:OW];
	assign in_range = (32'(page_in) < 32'(pages_q)) && (32'(page_in) < VIRT_PAGES);
	assign ro_hit   = req_type && (32'(page_in) < 32'(text_q));

	always_comb begin
		if (frames_q == 5'd0) begin
			nf = 9'd1;
		end else if (32'(frames_q) > FRAMES) begin
			nf = 9'(FRAMES);
		end else begin
			nf = 9'(frames_q);
		end
		ns = (32'(slots_q) < SWAP_SLOTS) ? 11'(slots_q) : 11'(SWAP_SLOTS);
	end

	assign pv   = pt_rdata[IW+2];
	assign pd   = pt_rdata[IW+1];
	assign ps   = pt_rdata[IW];
	assign pidx = pt_rdata[IW-1:0];
	assign e_swapped = e_q[IW];
	assign e_idx     = e_q[IW-1:0];

	// Frame scan: data for scan_q arrives while the read of the next frame goes out.
	assign cur_stamp = fm_rdata[STAMP_BITS-1:0];
	assign cur_own   = fm_rdata[FRW-1:STAMP_BITS];
	assign sc_free   = (cur_stamp == '0);
	assign sc_last   = (32'(scan_q) == 32'(nf) - 1);
	assign sc_better = (scan_q == '0) || (cur_stamp < min_q);
	assign sc_best   = sc_better ? scan_q : best_q;
	assign sc_own    = sc_better ? cur_own : bown_q;

	assign v_match  = pv && (pidx == IW'(frame_q));
	assign v_needwb = pd && (32'(vp_q) >= 32'(text_q));
	assign s_free   = !sm_rdata;
	assign s_last   = (32'(sw_q) == 32'(ns) - 1);

	dplt_ram #(.W(PEW), .D(VIRT_PAGES), .AW(PW)) u_pt (
		.clk, .arst_n, .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.re(pt_re), .raddr(pt_raddr), .rdata(pt_rdata)
	);

	dplt_ram #(.W(FRW), .D(FRAMES), .AW(FW)) u_fm (
		.clk, .arst_n, .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
		.re(fm_re), .raddr(fm_raddr), .rdata(fm_rdata)
	);

	dplt_ram #(.W(1), .D(SWAP_SLOTS), .AW(SW)) u_sm (
		.clk, .arst_n, .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
		.re(sm_re), .raddr(sm_raddr), .rdata(sm_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dplt_pkg::S_IDLE: begin
				if (start && in_range && !ro_hit) begin
					state_d = dplt_pkg::S_PT;
				end
			end
			dplt_pkg::S_PT: begin
				state_d = pv ? dplt_pkg::S_IDLE : dplt_pkg::S_SCAN;
			end
			dplt_pkg::S_SCAN: begin
				if (sc_free) begin
					state_d = dplt_pkg::S_FILL;
				end else if (sc_last) begin
					state_d = sc_own[PW] ? dplt_pkg::S_VPT : dplt_pkg::S_FILL;
				end
			end
			dplt_pkg::S_VPT: begin
				if (v_match && v_needwb) begin
					state_d = (ns == '0) ? dplt_pkg::S_IDLE : dplt_pkg::S_SWAP;
				end else begin
					state_d = dplt_pkg::S_FILL;
				end
			end
			dplt_pkg::S_SWAP: begin
				if (s_free) begin
					state_d = dplt_pkg::S_FILL;
				end else if (s_last) begin
					state_d = dplt_pkg::S_IDLE;
				end
			end
			dplt_pkg::S_FILL: state_d = dplt_pkg::S_IDLE;
			default: state_d = dplt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		pt_re = 1'b0; pt_raddr = '0; pt_we = 1'b0; pt_waddr = '0; pt_wdata = '0;
		fm_re = 1'b0; fm_raddr = '0; fm_we = 1'b0; fm_waddr = '0; fm_wdata = '0;
		sm_re = 1'b0; sm_raddr = '0; sm_we = 1'b0; sm_waddr = '0; sm_wdata = 1'b0;
		res_ld = 1'b0; r_status = dplt_pkg::STS_HIT; r_phys = '0;
		r_src = dplt_pkg::SRC_NONE; r_fidx = '0; r_ev = 1'b0; r_evp = '0;
		r_wb = 1'b0; r_wbs = '0; stamp_take = 1'b0;
		case (state_q)
			dplt_pkg::S_IDLE: begin
				if (start) begin
					if (!in_range) begin
						res_ld = 1'b1;
						r_status = dplt_pkg::STS_RANGE;
					end else if (ro_hit) begin
						res_ld = 1'b1;
						r_status = dplt_pkg::STS_RO;
					end else begin
						pt_re = 1'b1;
						pt_raddr = PW'(page_in);
					end
				end
			end
			dplt_pkg::S_PT: begin
				if (pv) begin
					res_ld = 1'b1;
					r_status = dplt_pkg::STS_HIT;
					r_phys = phys_of(FW'(pidx), off_q);
					if (req_q) begin
						pt_we = 1'b1;
						pt_waddr = page_q;
						pt_wdata = {1'b1, 1'b1, ps, pidx};
						fm_we = 1'b1;
						fm_waddr = FW'(pidx);
						fm_wdata = {1'b1, page_q, stamp_q};
						stamp_take = 1'b1;
					end
				end else begin
					fm_re = 1'b1;
					fm_raddr = '0;
				end
			end
			dplt_pkg::S_SCAN: begin
				if (!sc_free && !sc_last) begin
					fm_re = 1'b1;
					fm_raddr = FW'(scan_q + 1'b1);
				end else if (!sc_free && sc_own[PW]) begin
					pt_re = 1'b1;
					pt_raddr = sc_own[PW-1:0];
				end
			end
			dplt_pkg::S_VPT: begin
				if (v_match && v_needwb) begin
					if (ns == '0) begin
						res_ld = 1'b1;
						r_status = dplt_pkg::STS_FULL;
					end else begin
						sm_re = 1'b1;
						sm_raddr = '0;
					end
				end else if (v_match) begin
					pt_we = 1'b1;
					pt_waddr = vp_q;
					pt_wdata = '0;
				end
			end
			dplt_pkg::S_SWAP: begin
				if (s_free) begin
					sm_we = 1'b1;
					sm_waddr = sw_q;
					sm_wdata = 1'b1;
					// The written-back page stays dirty and remembers its slot.
					pt_we = 1'b1;
					pt_waddr = vp_q;
					pt_wdata = {1'b0, 1'b1, 1'b1, IW'(sw_q)};
				end else if (s_last) begin
					res_ld = 1'b1;
					r_status = dplt_pkg::STS_FULL;
				end else begin
					sm_re = 1'b1;
					sm_raddr = SW'(sw_q + 1'b1);
				end
			end
			dplt_pkg::S_FILL: begin
				res_ld = 1'b1;
				r_status = dplt_pkg::STS_FAULT;
				r_phys = phys_of(frame_q, off_q);
				r_ev = ev_q;
				r_evp = 6'(vp_q);
				r_wb = wb_q;
				r_wbs = 6'(wbs_q);
				if (e_swapped && (32'(e_idx) < SWAP_SLOTS)) begin
					sm_we = 1'b1;
					sm_waddr = SW'(e_idx);
					sm_wdata = 1'b0;
				end
				pt_we = 1'b1;
				pt_waddr = page_q;
				if (32'(page_q) < 32'(text_q)) begin
					r_src = dplt_pkg::SRC_EXE;
					r_fidx = 6'(page_q);
					pt_wdata = {1'b1, req_q, 1'b0, IW'(frame_q)};
				end else if (e_swapped) begin
					r_src = dplt_pkg::SRC_SWAP;
					r_fidx = 6'(e_idx);
					pt_wdata = {1'b1, 1'b1, 1'b0, IW'(frame_q)};
				end else if (32'(page_q) < 32'(text_q) + 32'(data_q)) begin
					r_src = dplt_pkg::SRC_EXE;
					r_fidx = 6'(page_q);
					pt_wdata = {1'b1, req_q, 1'b0, IW'(frame_q)};
				end else begin
					r_src = dplt_pkg::SRC_ZERO;
					pt_wdata = {1'b1, req_q, 1'b0, IW'(frame_q)};
				end
				fm_we = 1'b1;
				fm_waddr = frame_q;
				fm_wdata = {1'b1, page_q, stamp_q};
				stamp_take = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dplt_pkg::S_IDLE;
			text_q   <= 7'd0;
			data_q   <= 7'd0;
			pages_q  <= 7'd64;
			frames_q <= 5'd16;
			slots_q  <= 7'd64;
			stamp_q  <= STAMP_BITS'(1);
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_ld;
			if (stamp_take && stamp_q != StampMax) begin
				stamp_q <= stamp_q + 1'b1;
			end
			if (wr_en) begin
				case (wr_index)
					dplt_pkg::REG_TEXT:   text_q   <= wr_data;
					dplt_pkg::REG_DATA:   data_q   <= wr_data;
					dplt_pkg::REG_PAGES:  pages_q  <= wr_data;
					dplt_pkg::REG_FRAMES: frames_q <= wr_data[4:0];
					dplt_pkg::REG_SLOTS:  slots_q  <= wr_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dplt_pkg::S_IDLE && start) begin
			req_q  <= req_type;
			page_q <= PW'(page_in);
			off_q  <= vaddr[OW-1:0];
		end
		if (state_q == dplt_pkg::S_PT) begin
			e_q    <= pt_rdata;
			scan_q <= '0;
			ev_q   <= 1'b0;
			wb_q   <= 1'b0;
		end
		if (state_q == dplt_pkg::S_SCAN) begin
			scan_q <= FW'(scan_q + 1'b1);
			if (sc_better) begin
				min_q  <= cur_stamp;
				best_q <= scan_q;
				bown_q <= cur_own;
			end
			if (sc_free) begin
				frame_q <= scan_q;
			end else if (sc_last) begin
				frame_q <= sc_best;
				vp_q    <= sc_own[PW-1:0];
			end
		end
		if (state_q == dplt_pkg::S_VPT) begin
			sw_q <= '0;
			if (v_match && !v_needwb) begin
				ev_q <= 1'b1;
			end
		end
		if (state_q == dplt_pkg::S_SWAP) begin
			sw_q <= SW'(sw_q + 1'b1);
			if (s_free) begin
				ev_q  <= 1'b1;
				wb_q  <= 1'b1;
				wbs_q <= sw_q;
			end
		end
		if (res_ld) begin
			status_q <= r_status;
			phys_q   <= r_phys;
			src_q    <= r_src;
			fidx_q   <= r_fidx;
			ev_o_q   <= r_ev;
			evp_o_q  <= r_ev ? r_evp : 6'd0;
			wb_o_q   <= r_wb;
			wbs_o_q  <= r_wb ? r_wbs : 6'd0;
		end
	end

	assign busy            = (state_q != dplt_pkg::S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign paddr           = phys_q;
	assign fill_source     = src_q;
	assign fill_index      = fidx_q;
	assign evict_valid     = ev_o_q;
	assign evict_page      = evp_o_q;
	assign writeback_valid = wb_o_q;
	assign writeback_slot  = wbs_o_q;

endmodule

// ===== src/dplt_checker.sv =====
// Port-level checker for the paging translator and its bind to the top level.
`timescale 1ns / 1ps
module dplt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status,
	input logic [9:0] paddr,
	input logic [1:0] fill_source,
	input logic       evict_valid,
	input logic       writeback_valid
);

	// A result beat follows an accepted beat or work in progress.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result beat without a request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= dplt_pkg::STS_FULL))
		else $error("undefined status code");

	a_no_fill_unless_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != dplt_pkg::STS_FAULT) |->
		(fill_source == dplt_pkg::SRC_NONE && !evict_valid && !writeback_valid))
		else $error("fill or eviction outside a serviced fault");

	a_wb_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && writeback_valid) |-> evict_valid)
		else $error("write-back without an eviction");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == dplt_pkg::STS_RANGE || status == dplt_pkg::STS_RO ||
		status == dplt_pkg::STS_FULL)) |-> (paddr == 10'd0))
		else $error("rejected access carries an address");

endmodule

bind demand_paging_lru_translator_unit dplt_checker u_dplt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.paddr(paddr),
	.fill_source(fill_source),
	.evict_valid(evict_valid),
	.writeback_valid(writeback_valid)
);

// ===== dv/demand_paging_lru_translator_unit_test.sv =====
// Self-checking testbench for the demand-paging LRU address translator.
`timescale 1ns / 1ps

typedef struct {
	logic [2:0] status;
	logic [9:0] paddr;
	logic [1:0] fill_source;
	logic [5:0] fill_index;
	logic       evict_valid;
	logic [5:0] evict_page;
	logic       writeback_valid;
	logic [5:0] writeback_slot;
} xlate_result_t;

class xlate_scoreboard;
	bit              pg_valid[64];
	bit              pg_dirty[64];
	bit              pg_swapped[64];
	int unsigned     pg_index[64];
	longint unsigned frame_stamp[16];
	bit              owner_valid[16];
	int unsigned     owner_page[16];
	bit              slot_busy[64];
	longint unsigned next_stamp;
	int unsigned     text_cnt, data_cnt, page_lim, frame_cnt, slot_cnt;
	xlate_result_t   pending[$];
	int              errors, requests, faults, evictions, writebacks, swap_fulls;

	function void clear();
		for (int i = 0; i < 64; i++) begin
			pg_valid[i] = 0; pg_dirty[i] = 0; pg_swapped[i] = 0; pg_index[i] = 0;
			slot_busy[i] = 0;
		end
		for (int i = 0; i < 16; i++) begin
			frame_stamp[i] = 0; owner_valid[i] = 0; owner_page[i] = 0;
		end
		next_stamp = 1;
		text_cnt = 0; data_cnt = 0; page_lim = 64; frame_cnt = 16; slot_cnt = 64;
	endfunction

	function void write_reg(logic [2:0] idx, logic [6:0] val);
		case (idx)
			dplt_pkg::REG_TEXT:   text_cnt = val;
			dplt_pkg::REG_DATA:   data_cnt = val;
			dplt_pkg::REG_PAGES:  page_lim = val;
			dplt_pkg::REG_FRAMES: frame_cnt = val[4:0];
			dplt_pkg::REG_SLOTS:  slot_cnt = val;
			default: ;
		endcase
	endfunction

	function longint unsigned grab_stamp();
		longint unsigned s;
		s = next_stamp;
		if (next_stamp < 64'hFFFF_FFFF) next_stamp++;
		return s;
	endfunction

	function void note_request(bit st, logic [11:0] va);
		xlate_result_t r;
		int unsigned pg, off, lim, nf, ns, fr, vp, s;
		bit found;
		r = '{default: '0};
		pg = va[11:6];
		off = va[5:0];
		lim = page_lim < 64 ? page_lim : 64;
		requests++;
		if (pg >= lim) begin
			r.status = dplt_pkg::STS_RANGE;
		end else if (st && pg < text_cnt) begin
			r.status = dplt_pkg::STS_RO;
		end else if (pg_valid[pg]) begin
			fr = pg_index[pg] % 16;
			if (st) begin
				pg_dirty[pg] = 1;
				frame_stamp[fr] = grab_stamp();
			end
			r.status = dplt_pkg::STS_HIT;
			r.paddr = 10'(fr * 64 + off);
		end else begin
			nf = frame_cnt < 1 ? 1 : (frame_cnt > 16 ? 16 : frame_cnt);
			ns = slot_cnt < 64 ? slot_cnt : 64;
			found = 0;
			fr = 0;
			for (int f = 0; f < nf; f++) begin
				if (!found && frame_stamp[f] == 0) begin
					fr = f; found = 1;
				end
			end
			if (!found) begin
				fr = 0;
				for (int f = 1; f < nf; f++)
					if (frame_stamp[f] < frame_stamp[fr]) fr = f;
				vp = owner_page[fr];
				if (owner_valid[fr] && vp < 64 && pg_valid[vp] && pg_index[vp] == fr) begin
					if (pg_dirty[vp] && vp >= text_cnt) begin
						for (s = 0; s < ns; s++)
							if (!slot_busy[s]) break;
						if (s >= ns) begin
							// Swap is exhausted: the request is refused and no state moves.
							r.status = dplt_pkg::STS_FULL;
							swap_fulls++;
							pending.push_back(r);
							return;
						end
						slot_busy[s] = 1;
						pg_valid[vp] = 0; pg_swapped[vp] = 1; pg_index[vp] = s;
						r.writeback_valid = 1;
						r.writeback_slot = s;
						writebacks++;
					end else begin
						pg_valid[vp] = 0; pg_dirty[vp] = 0; pg_swapped[vp] = 0;
						pg_index[vp] = 0;
					end
					r.evict_valid = 1;
					r.evict_page = vp;
					evictions++;
				end
			end
			if (pg_swapped[pg] && pg_index[pg] < 64) slot_busy[pg_index[pg]] = 0;
			if (pg < text_cnt) begin
				r.fill_source = dplt_pkg::SRC_EXE; r.fill_index = pg; pg_dirty[pg] = 0;
			end else if (pg_swapped[pg]) begin
				r.fill_source = dplt_pkg::SRC_SWAP; r.fill_index = pg_index[pg];
				pg_dirty[pg] = 1;
			end else if (pg < text_cnt + data_cnt) begin
				r.fill_source = dplt_pkg::SRC_EXE; r.fill_index = pg; pg_dirty[pg] = 0;
			end else begin
				r.fill_source = dplt_pkg::SRC_ZERO; pg_dirty[pg] = 0;
			end
			pg_swapped[pg] = 0;
			pg_valid[pg] = 1;
			pg_index[pg] = fr;
			if (st) pg_dirty[pg] = 1;
			owner_valid[fr] = 1;
			owner_page[fr] = pg;
			frame_stamp[fr] = grab_stamp();
			r.status = dplt_pkg::STS_FAULT;
			r.paddr = 10'(fr * 64 + off);
			faults++;
		end
		pending.push_back(r);
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(xlate_result_t got);
		xlate_result_t want;
		if (pending.size() == 0) begin
			$display("%0t: result beat with nothing expected, status %0d", $realtime,
				got.status);
			errors++;
			return;
		end
		want = pending.pop_front();
		compare_field("status", want.status, got.status);
		compare_field("paddr", want.paddr, got.paddr);
		compare_field("fill_source", want.fill_source, got.fill_source);
		compare_field("fill_index", want.fill_index, got.fill_index);
		compare_field("evict_valid", want.evict_valid, got.evict_valid);
		compare_field("evict_page", want.evict_page, got.evict_page);
		compare_field("writeback_valid", want.writeback_valid, got.writeback_valid);
		compare_field("writeback_slot", want.writeback_slot, got.writeback_slot);
	endfunction
endclass

module demand_paging_lru_translator_unit_test;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       start = 0;
	logic       req_type = 0;
	logic [11:0] vaddr = '0;
	logic       wr_en = 0;
	logic [2:0] wr_index = '0;
	logic [6:0] wr_data = '0;
	logic       busy, done, evict_valid, writeback_valid;
	logic [2:0] status;
	logic [9:0] paddr;
	logic [1:0] fill_source;
	logic [5:0] fill_index, evict_page, writeback_slot;

	xlate_scoreboard sb = new();
	int idle_cycles = 0;

	demand_paging_lru_translator_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .vaddr(vaddr), .done(done), .status(status),
		.paddr(paddr), .fill_source(fill_source), .fill_index(fill_index),
		.evict_valid(evict_valid), .evict_page(evict_page),
		.writeback_valid(writeback_valid), .writeback_slot(writeback_slot),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		xlate_result_t got;
		if (done) begin
			got.status = status;
			got.paddr = paddr;
			got.fill_source = fill_source;
			got.fill_index = fill_index;
			got.evict_valid = evict_valid;
			got.evict_page = evict_page;
			got.writeback_valid = writeback_valid;
			got.writeback_slot = writeback_slot;
			sb.check_result(got);
		end
	end

	// Any accepted beat on either side restarts the hang detector.
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 4000) begin
			$display("%0t: timeout, nothing accepted for %0d cycles", $realtime, idle_cycles);
			$display("demand_paging_lru_translator_unit_test NOT OK");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(bit st, logic [11:0] va, int gap);
		start <= 1;
		req_type <= st;
		vaddr <= va;
		do @(posedge clk); while (!(start && !busy));
		sb.note_request(st, va);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [6:0] val);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		wr_en <= 0;
		@(posedge clk);
	endtask

	initial begin
		int t[5];
		int base, span, p, n_phase;
		bit st;
		logic [11:0] va;
		sb.clear();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Fill every frame, then one more page to force the first LRU eviction.
		for (int i = 0; i <= 16; i++) send_request(i[0], {i[5:0], 6'd0}, 0);
		send_request(1, 12'd1 << 6 | 12'd63, 1);
		send_request(0, 12'hFFF, 0);
		send_request(1, 12'hFFF, 0);
		send_request(0, 12'h000, 2);
		send_request(1, 12'h0AA, 0);
		send_request(0, 12'h555, 0);
		drain();

		n_phase = 10;
		for (int ph = 0; ph < n_phase; ph++) begin
			case (ph)
				0: t = '{4, 8, 40, 4, 3};
				1: t = '{64, 0, 64, 1, 64};
				2: t = '{10, 20, 64, 2, 0};
				3: t = '{2, 3, 20, 31, 127};
				4: t = '{0, 64, 1, 16, 1};
				5: t = '{127, 127, 64, 0, 2};
				6: t = '{0, 0, 64, 3, 1};
				default: t = '{$urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 31), $urandom_range(0, 127)};
			endcase
			write_reg(dplt_pkg::REG_TEXT, 7'(t[0]));
			write_reg(dplt_pkg::REG_DATA, 7'(t[1]));
			write_reg(dplt_pkg::REG_PAGES, 7'(t[2]));
			write_reg(dplt_pkg::REG_FRAMES, 7'(t[3]));
			write_reg(dplt_pkg::REG_SLOTS, 7'(t[4]));
			write_reg(3'(5 + $urandom_range(0, 2)), 7'($urandom_range(0, 127)));
			// A working set a little larger than the frame count keeps faults and
			// evictions frequent while still leaving room for hits.
			span = (t[3] == 0 ? 1 : (t[3] > 16 ? 16 : t[3])) + $urandom_range(1, 4);
			for (int k = 0; k < 160; k++) begin
				if (k % 40 == 0) base = $urandom_range(0, 63);
				st = $urandom_range(0, 1);
				if ($urandom_range(0, 99) < 85) p = (base + $urandom_range(0, span - 1)) % 64;
				else p = $urandom_range(0, 63);
				va = {p[5:0], 6'($urandom_range(0, 63))};
				send_request(st, va, pick_gap());
				if ($urandom_range(0, 149) == 0) drain();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Sent %0d requests over %0d register settings.", sb.requests, n_phase + 1);
		$display("Saw %0d faults, %0d evictions, %0d write-backs and %0d swap-full refusals.",
			sb.faults, sb.evictions, sb.writebacks, sb.swap_fulls);
		if (sb.pending.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $realtime, sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("demand_paging_lru_translator_unit_test OK");
		end else begin
			$display("demand_paging_lru_translator_unit_test NOT OK");
		end
		$finish;
	end
endmodule
